### hw/rtl/tafq_pkg.sv
package tafq_pkg;

  // Filter geometry
  localparam int TAPS        = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int AXES        = 3;

  // Coefficient ROM
  localparam int ROM_TAPS    = 16;
  localparam int ROM_SETS    = 10;
  localparam int DEFAULT_SET = 4;
  localparam int COEF_W      = 9;
  localparam int COEF_FRAC   = 8;
  localparam int SET_W       = 4;
  localparam int ROM_TAP_W   = $clog2(ROM_TAPS);

  // Derived widths
  localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int AXIS_W    = $clog2(AXES);
  localparam int OUT_W     = 17;
  localparam int PROD_W    = SAMPLE_BITS + COEF_W;
  localparam int SHIFT_W   = PROD_W - COEF_FRAC;
  localparam int ACC_SUM_W = SHIFT_W + TAP_W + 1;
  localparam int ACC_W     = (ACC_SUM_W > OUT_W + 1) ? ACC_SUM_W : OUT_W + 1;
  localparam int S_DATA_W  = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_DATA_W  = ((AXES * OUT_W + 7) / 8) * 8;

  // Output saturation bounds
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(2 ** (OUT_W - 1)));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [OUT_W-1:0]       out_t;

  // Issue-side control for the shared multiply-accumulate unit
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [AXIS_W-1:0] axis;
  } mac_ctrl_t;

  // Completion status from the multiply-accumulate unit
  typedef struct packed {
    logic              vld;
    logic [AXIS_W-1:0] axis;
  } mac_stat_t;

  // Q8 coefficient sets: low-pass first, then progressively wider bands
  localparam coef_t COEF_ROM [ROM_SETS][ROM_TAPS] = '{
    '{ 9'sd3,  9'sd5,  9'sd9,  9'sd13, 9'sd18, 9'sd22, 9'sd25, 9'sd27,
       9'sd27, 9'sd25, 9'sd22, 9'sd18, 9'sd13, 9'sd9,  9'sd5,  9'sd3 },
    '{ -9'sd2, -9'sd4, -9'sd3, 9'sd1,  9'sd11, 9'sd25, 9'sd39, 9'sd48,
       9'sd48, 9'sd40, 9'sd27, 9'sd13, 9'sd2,  -9'sd3, -9'sd4, -9'sd3 },
    '{ 9'sd1,  9'sd0,  -9'sd4, -9'sd10, -9'sd6, 9'sd12, 9'sd41, 9'sd64,
       9'sd66, 9'sd46, 9'sd16, -9'sd4, -9'sd10, -9'sd5, 9'sd0,  9'sd1 },
    '{ 9'sd3,  9'sd6,  9'sd1,  -9'sd10, -9'sd14, 9'sd5, 9'sd47, 9'sd83,
       9'sd84, 9'sd50, 9'sd7,  -9'sd14, -9'sd11, 9'sd0, 9'sd6,  9'sd4 },
    '{ -9'sd3, -9'sd1, 9'sd7,  9'sd7,  -9'sd12, -9'sd16, 9'sd32, 9'sd97,
       9'sd101, 9'sd40, -9'sd13, -9'sd14, 9'sd5, 9'sd8, 9'sd0,  -9'sd3 },
    '{ 9'sd0,  -9'sd5, -9'sd4, 9'sd10, 9'sd1,  -9'sd25, 9'sd15, 9'sd109,
       9'sd116, 9'sd25, -9'sd25, -9'sd1, 9'sd11, -9'sd3, -9'sd6, 9'sd0 },
    '{ 9'sd5,  9'sd1,  -9'sd8, 9'sd6,  9'sd10, -9'sd26, 9'sd6,  9'sd124,
       9'sd129, 9'sd12, -9'sd28, 9'sd9, 9'sd7, -9'sd8, 9'sd1,  9'sd5 },
    '{ -9'sd4, 9'sd1,  9'sd4,  -9'sd11, 9'sd14, -9'sd6, -9'sd22, 9'sd125,
       9'sd141, -9'sd12, -9'sd13, 9'sd16, -9'sd10, 9'sd2, 9'sd2, -9'sd4 },
    '{ -9'sd7, 9'sd2,  9'sd3,  -9'sd12, 9'sd18, -9'sd12, -9'sd19, 9'sd149,
       9'sd149, -9'sd19, -9'sd12, 9'sd18, -9'sd12, 9'sd3, 9'sd2, -9'sd7 },
    '{ 9'sd0,  -9'sd8, 9'sd9,  -9'sd10, 9'sd5, 9'sd7, -9'sd36, 9'sd156,
       9'sd156, -9'sd36, 9'sd7, 9'sd5, -9'sd10, 9'sd9, -9'sd8, 9'sd0 }
  };

  // Look up one coefficient; unknown sets fall back to the default set,
  // taps past the end of the ROM weigh zero
  function automatic coef_t coef_lookup(logic [SET_W-1:0] set_sel, logic [TAP_W-1:0] tap);
    logic [SET_W-1:0] set_idx;
    coef_t            coef;
    set_idx = (set_sel < SET_W'(ROM_SETS)) ? set_sel : SET_W'(DEFAULT_SET);
    if (int'(tap) < ROM_TAPS) begin
      coef = COEF_ROM[set_idx][ROM_TAP_W'(tap)];
    end else begin
      coef = '0;
    end
    return coef;
  endfunction

endpackage

### hw/rtl/tafq_mac.sv
module tafq_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tafq_pkg::mac_ctrl_t   ctrl_i,
  input  tafq_pkg::sample_t     sample_i,
  input  tafq_pkg::coef_t       coef_i,
  output tafq_pkg::mac_stat_t   stat_o,
  output tafq_pkg::out_t        sum_o
);
  import tafq_pkg::*;

  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  mac_ctrl_t                 ctrl_q;
  logic signed [SHIFT_W-1:0] shifted;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   acc_q;
  out_t                      sat_d;
  out_t                      sum_q;
  mac_stat_t                 stat_q;

  // Multiply one sample by one coefficient
  assign prod_d = sample_i * coef_i;

  // Floor the product by dropping the fraction bits, then accumulate
  assign shifted = prod_q[PROD_W-1:COEF_FRAC];
  assign term    = ACC_W'(shifted);
  assign acc_d   = ctrl_q.first ? term : acc_q + term;

  // Clamp the finished sum to the output range
  always_comb begin
    if (acc_d > OUT_MAX) begin
      sat_d = OUT_MAX[OUT_W-1:0];
    end else if (acc_d < OUT_MIN) begin
      sat_d = OUT_MIN[OUT_W-1:0];
    end else begin
      sat_d = acc_d[OUT_W-1:0];
    end
  end

  // Product register, then accumulator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      stat_q <= '0;
    end else begin
      ctrl_q     <= ctrl_i;
      stat_q.vld <= ctrl_q.vld && ctrl_q.last;
      stat_q.axis <= ctrl_q.axis;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_q.vld) begin
      acc_q <= acc_d;
    end
    if (ctrl_q.vld && ctrl_q.last) begin
      sum_q <= sat_d;
    end
  end

  assign stat_o = stat_q;
  assign sum_o  = sum_q;

  // A finished sum always follows, in the next cycle, the last tap of an axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q.vld |-> $past(ctrl_q.vld && ctrl_q.last))
    else $error("mac: sum completed without a last tap");

endmodule

### hw/rtl/three_axis_fir_q8_filter.sv
// Channel  | Direction | Handshake                    | Content
// s_axis   | in        | s_axis_tvalid/tready         | one three-axis reading
// m_axis   | out       | m_axis_tvalid/tready         | one three-axis filtered result
// cfg      | in        | cfg_valid/cfg_ready          | coefficient set index
//
// From acceptance to a result in the output register, a reading passes
// through the single shared multiplier once per tap of each axis (3 axes x
// 16 taps), then the last sum is finished, captured and loaded into the
// output; the sequencer then returns to idle and takes the next reading.
// s_axis_tready is high only while the sequencer is idle. A result held by a
// stalled m_axis side does not block acceptance; the next result waits in the
// sequencer until the output register is free. Reset clears the delay lines,
// the set index (first low-pass set) and all handshake state.
module three_axis_fir_q8_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // sample_x [15:0], sample_y [31:16], sample_z [47:32]
  input  logic [tafq_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // filt_x [16:0], filt_y [33:17], filt_z [50:34], zero [55:51]
  output logic [tafq_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tafq_pkg::SET_W-1:0]    cfg_data_i
);
  import tafq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [TAP_W-1:0]     tap_q;
  logic [AXIS_W-1:0]    axis_q;
  logic [SET_W-1:0]     set_q;
  sample_t              lines_q [AXES][TAPS];
  out_t                 res_q   [AXES];
  logic                 m_valid_q;
  logic [M_DATA_W-1:0]  m_data_q;
  logic [M_DATA_W-1:0]  m_data_d;
  logic                 in_req;
  logic                 out_load;
  logic                 tap_last;
  logic                 axis_last;
  mac_ctrl_t            mac_ctrl;
  sample_t              mac_sample;
  coef_t                mac_coef;
  mac_stat_t            mac_stat;
  out_t                 mac_sum;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);
  assign tap_last        = (tap_q == TAP_W'(TAPS - 1));
  assign axis_last       = (axis_q == AXIS_W'(AXES - 1));

  // Issue one tap of the current axis; its sample sits at the head of the line
  assign mac_ctrl.vld   = (state_q == ST_RUN);
  assign mac_ctrl.first = (tap_q == '0);
  assign mac_ctrl.last  = tap_last;
  assign mac_ctrl.axis  = axis_q;
  assign mac_sample     = lines_q[axis_q][0];
  assign mac_coef       = coef_lookup(set_q, tap_q);

  tafq_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (mac_sample),
    .coef_i   (mac_coef),
    .stat_o   (mac_stat),
    .sum_o    (mac_sum)
  );

  // Shift new samples in on a request; rotate the active line while filtering
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        for (int j = 0; j < TAPS; j++) begin
          lines_q[a][j] <= '0;
        end
      end
    end else if (in_req) begin
      for (int a = 0; a < AXES; a++) begin
        lines_q[a][0] <= s_axis_tdata_i[a*SAMPLE_BITS +: SAMPLE_BITS];
        for (int j = 1; j < TAPS; j++) begin
          lines_q[a][j] <= lines_q[a][j-1];
        end
      end
    end else if (state_q == ST_RUN) begin
      for (int a = 0; a < AXES; a++) begin
        if (AXIS_W'(a) == axis_q) begin
          for (int j = 0; j < TAPS - 1; j++) begin
            lines_q[a][j] <= lines_q[a][j+1];
          end
          lines_q[a][TAPS-1] <= lines_q[a][0];
        end
      end
    end
  end

  // Pack the three axis results for the output register
  always_comb begin
    m_data_d = '0;
    for (int a = 0; a < AXES; a++) begin
      m_data_d[a*OUT_W +: OUT_W] = res_q[a];
    end
  end

  // Sequencer, configuration register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= '0;
      axis_q    <= '0;
      set_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        set_q <= cfg_data_i;
      end
      // Present a new result, or drop the one just taken
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            tap_q   <= '0;
            axis_q  <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap_last) begin
            tap_q <= '0;
            if (axis_last) begin
              axis_q  <= '0;
              state_q <= ST_DRAIN;
            end else begin
              axis_q <= axis_q + 1'b1;
            end
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (mac_stat.vld && (mac_stat.axis == AXIS_W'(AXES - 1))) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture finished axis sums and load the output payload
  always_ff @(posedge clk_i) begin
    if (mac_stat.vld) begin
      res_q[mac_stat.axis] <= mac_sum;
    end
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Sums come back only while an item is being filtered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_stat.vld |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("filter: sum returned outside filtering");

  // A new result is presented only after the sequencer delivered one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_OUT))
    else $error("filter: result presented without a finished item");

  // The tap counter wraps only when an axis is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !tap_last) |=> (tap_q != '0))
    else $error("filter: tap counter wrapped early");

  // The last axis finishing ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && tap_last && axis_last) |=> (state_q == ST_DRAIN))
    else $error("filter: run did not end after the last tap");

endmodule

### dv/three_axis_fir_q8_filter_test.sv
`timescale 1ns / 1ps

module three_axis_fir_q8_filter_test;

  import tafq_pkg::*;

  // Coefficient sets, Q8, one row per set index
  localparam int SET_COUNT    = 10;
  localparam int FALLBACK_SET = 4;
  localparam int ROW_TAPS     = 16;
  localparam int COEF_TABLE [SET_COUNT][ROW_TAPS] = '{
    '{  3,   5,   9,  13,  18,  22,  25,  27,  27,  25,  22,  18,  13,   9,   5,   3 },
    '{ -2,  -4,  -3,   1,  11,  25,  39,  48,  48,  40,  27,  13,   2,  -3,  -4,  -3 },
    '{  1,   0,  -4, -10,  -6,  12,  41,  64,  66,  46,  16,  -4, -10,  -5,   0,   1 },
    '{  3,   6,   1, -10, -14,   5,  47,  83,  84,  50,   7, -14, -11,   0,   6,   4 },
    '{ -3,  -1,   7,   7, -12, -16,  32,  97, 101,  40, -13, -14,   5,   8,   0,  -3 },
    '{  0,  -5,  -4,  10,   1, -25,  15, 109, 116,  25, -25,  -1,  11,  -3,  -6,   0 },
    '{  5,   1,  -8,   6,  10, -26,   6, 124, 129,  12, -28,   9,   7,  -8,   1,   5 },
    '{ -4,   1,   4, -11,  14,  -6, -22, 125, 141, -12, -13,  16, -10,   2,   2,  -4 },
    '{ -7,   2,   3, -12,  18, -12, -19, 149, 149, -19, -12,  18, -12,   3,   2,  -7 },
    '{  0,  -8,   9, -10,   5,   7, -36, 156, 156, -36,   7,   5, -10,   9,  -8,   0 }
  };
  localparam longint FILT_MAX = 65535;
  localparam longint FILT_MIN = -65536;

  typedef struct packed {
    out_t z;
    out_t y;
    out_t x;
  } filt_triplet_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [S_DATA_W-1:0]   s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [SET_W-1:0]      cfg_data_i = '0;

  logic [S_DATA_W-1:0]   readings_to_send[$];
  filt_triplet_t         filtered_due[$];
  sample_t               history [3][TAPS];
  logic [SET_W-1:0]      active_set = '0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    recv_stall_left = 0;
  int                    mismatch_count = 0;

  three_axis_fir_q8_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      for (int t = 0; t < TAPS; t++) begin
        history[a][t] = '0;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Shift one reading into the delay lines and queue the filtered triplet
  task automatic filter_reading(input logic [S_DATA_W-1:0] data);
    out_t          axis_out [3];
    filt_triplet_t res;
    longint        acc;
    longint        prod;
    longint        coef;
    int            set_idx;
    set_idx = (active_set < SET_COUNT) ? int'(active_set) : FALLBACK_SET;
    for (int a = 0; a < 3; a++) begin
      for (int t = TAPS - 1; t > 0; t--) begin
        history[a][t] = history[a][t-1];
      end
      history[a][0] = data[a*SAMPLE_BITS +: SAMPLE_BITS];
      acc = 0;
      for (int t = 0; t < TAPS; t++) begin
        coef = (t < ROW_TAPS) ? longint'(COEF_TABLE[set_idx][t]) : 0;
        prod = longint'(history[a][t]) * coef;
        // arithmetic shift floors every product before it is summed
        acc += prod >>> 8;
      end
      if (acc > FILT_MAX) acc = FILT_MAX;
      if (acc < FILT_MIN) acc = FILT_MIN;
      axis_out[a] = acc[16:0];
    end
    res.x = axis_out[0];
    res.y = axis_out[1];
    res.z = axis_out[2];
    filtered_due.push_back(res);
  endtask

  // Driver: present queued readings, holding each request until taken
  always @(posedge clk_i) begin
    logic taken;
    logic next_valid;
    taken      = s_axis_tvalid_i && s_axis_tready_o;
    next_valid = 1'b0;
    if (taken) begin
      filter_reading(readings_to_send.pop_front());
    end
    if (s_axis_tvalid_i && !taken) begin
      next_valid = 1'b1;
    end else if (rst_ni && readings_to_send.size() > 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      next_valid = 1'b1;
      s_axis_tdata_i <= readings_to_send[0];
    end
    s_axis_tvalid_i <= next_valid;
  end

  // Receiver: random short stalls, and now and then a long one
  always @(posedge clk_i) begin
    if (recv_stall_left > 0) begin
      recv_stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) == 0) begin
      recv_stall_left = $urandom_range(20, 120);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    filt_triplet_t due;
    out_t          got_x;
    out_t          got_y;
    out_t          got_z;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_x = m_axis_tdata_o[16:0];
      got_y = m_axis_tdata_o[33:17];
      got_z = m_axis_tdata_o[50:34];
      if (m_axis_tdata_o[M_DATA_W-1:51] != '0) begin
        report_mismatch($sformatf("padding bits not zero: %h", m_axis_tdata_o));
      end
      if (filtered_due.size() == 0) begin
        report_mismatch($sformatf("result with none awaited: %h", m_axis_tdata_o));
      end else begin
        due = filtered_due.pop_front();
        if (got_x != due.x) begin
          report_mismatch($sformatf("filt_x expected %0d got %0d", due.x, got_x));
        end
        if (got_y != due.y) begin
          report_mismatch($sformatf("filt_y expected %0d got %0d", due.y, got_y));
        end
        if (got_z != due.z) begin
          report_mismatch($sformatf("filt_z expected %0d got %0d", due.z, got_z));
        end
      end
    end
  end

  function automatic logic [S_DATA_W-1:0] make_reading(input int x, input int y, input int z);
    logic [S_DATA_W-1:0] r;
    r = '0;
    r[15:0]  = x[15:0];
    r[31:16] = y[15:0];
    r[47:32] = z[15:0];
    return r;
  endfunction

  // Mostly full-range values, with small values and extremes mixed in
  function automatic int random_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      v = $urandom_range(0, 65535);
    end else if (pick == 6) begin
      v = int'($urandom_range(0, 600)) - 300;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = -1;
        default: v = 0;
      endcase
    end
    return v;
  endfunction

  task automatic wait_for_drain();
    while (readings_to_send.size() != 0 || filtered_due.size() != 0 || s_axis_tvalid_i) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_coef_set(input logic [SET_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    active_set = value;
  endtask

  task automatic queue_random_readings(input int count);
    for (int i = 0; i < count; i++) begin
      readings_to_send.push_back(make_reading(random_sample(), random_sample(),
                                              random_sample()));
    end
  endtask

  initial begin
    logic [SET_W-1:0] set_plan [12];
    set_plan = '{4'd9, 4'd15, 4'd1, 4'd2, 4'd10, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
                 4'($urandom_range(0, 15))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: impulse through every tap of the reset set, then extremes
    send_idle_pct = 38;
    recv_idle_pct = 46;
    readings_to_send.push_back(make_reading(32767, -32768, -1));
    repeat (15) readings_to_send.push_back(make_reading(0, 0, 0));
    readings_to_send.push_back(make_reading(-32768, 32767, 1));
    readings_to_send.push_back(make_reading(-32768, 32767, 1));
    readings_to_send.push_back(make_reading(32767, -32768, 0));
    readings_to_send.push_back(make_reading(-1, -1, -1));
    readings_to_send.push_back(make_reading(1, 1, 1));
    readings_to_send.push_back(make_reading(32767, 32767, 32767));
    readings_to_send.push_back(make_reading(-32768, -32768, -32768));
    readings_to_send.push_back(make_reading(0, 0, 0));

    // Random: one coefficient set per phase, idling pattern per group of four
    for (int p = 0; p < 12; p++) begin
      wait_for_drain();
      repeat (4) @(posedge clk_i);
      if (p < 4) begin
        send_idle_pct = 38;
        recv_idle_pct = 46;
      end else if (p < 8) begin
        send_idle_pct = 46;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_coef_set(set_plan[p]);
      if (p == 0) begin
        // hold the sender off mid-phase until everything has come back
        queue_random_readings(16);
        wait_for_drain();
        queue_random_readings(17);
      end else begin
        queue_random_readings(33);
      end
    end

    wait_for_drain();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
hw/rtl/tafq_pkg.sv
hw/rtl/tafq_mac.sv
hw/rtl/three_axis_fir_q8_filter.sv
dv/three_axis_fir_q8_filter_test.sv
